// ===== design/pltn_pkg.sv =====
// ----------------------------------------------------------------------------
// pltn_pkg
// Shared types and constants for the point light table with closest search.
// ----------------------------------------------------------------------------
package pltn_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned RadiusW = 16;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned HandleW = 6;
  localparam int unsigned CountW  = 7;

  // squared distance cap, exclusive
  localparam int unsigned DistCapW = 24;
  localparam logic [DistCapW-1:0] DIST_CAP = 24'd10000000;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_UPDATE = 3'd1,
    OP_REMOVE = 3'd2,
    OP_FIND   = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_HANDLE = 2'd2,
    ST_NONE_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ_WAIT,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [RadiusW-1:0]       radius;
    logic [ColorW-1:0]        red;
    logic [ColorW-1:0]        green;
    logic [ColorW-1:0]        blue;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture the input word
    logic decide;      // latch status and handle of simple ops
    logic append;      // write the captured entry at the end of the table
    logic update;      // overwrite the entry at the handle
    logic rd_handle;   // read the entry at the handle
    logic scan_init;   // start a closest scan at entry zero
    logic shift_init;  // start a shift at the entry after the handle
    logic step;        // issue the next read of a scan or shift
    logic shrink;      // drop one entry from the count
    logic finish;      // load the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic full;
    logic bad_handle;
    logic scan_done;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/pltn_ctrl.sv =====
// ----------------------------------------------------------------------------
// pltn_ctrl
// Sequencer for the light table: decodes one word at a time and steps the
// datapath through append, update, read, shift and scan.
// ----------------------------------------------------------------------------
module pltn_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  pltn_pkg::dp_status_t   dp_status_i,
  output pltn_pkg::ctrl_cmd_t    cmd_o
);
  import pltn_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_FINISH;
        case (dp_status_i.op)
          OP_ADD: begin
            cmd_o.append = !dp_status_i.full;
          end
          OP_UPDATE: begin
            cmd_o.update = !dp_status_i.bad_handle;
          end
          OP_REMOVE: begin
            if (!dp_status_i.bad_handle) begin
              cmd_o.shift_init = 1'b1;
              state_d          = S_SHIFT;
            end
          end
          OP_READ: begin
            if (!dp_status_i.bad_handle) begin
              cmd_o.rd_handle = 1'b1;
              state_d         = S_READ_WAIT;
            end
          end
          OP_FIND: begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_READ_WAIT: begin
        state_d = S_FINISH;
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (dp_status_i.scan_done && !dp_status_i.pipe_busy) begin
          state_d = S_FINISH;
        end
      end
      S_SHIFT: begin
        cmd_o.step = 1'b1;
        if (dp_status_i.scan_done && !dp_status_i.pipe_busy) begin
          cmd_o.shrink = 1'b1;
          state_d      = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold the result until the output register is free
        if (dp_status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/pltn_datapath.sv =====
// ----------------------------------------------------------------------------
// pltn_datapath
// Entry memory, live count, distance pipeline and output register of the
// light table.
// ----------------------------------------------------------------------------
module pltn_datapath #(
  parameter int unsigned MAX_LIGHTS = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pltn_pkg::ctrl_cmd_t                    cmd_i,
  output pltn_pkg::dp_status_t                   dp_status_o,
  input  logic [2:0]                             op_i,
  input  logic [pltn_pkg::HandleW-1:0]           handle_i,
  input  logic signed [pltn_pkg::CoordW-1:0]     pos_x_i,
  input  logic signed [pltn_pkg::CoordW-1:0]     pos_y_i,
  input  logic [pltn_pkg::RadiusW-1:0]           radius_i,
  input  logic [pltn_pkg::ColorW-1:0]            red_i,
  input  logic [pltn_pkg::ColorW-1:0]            green_i,
  input  logic [pltn_pkg::ColorW-1:0]            blue_i,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic [1:0]                             status_o,
  output logic [pltn_pkg::HandleW-1:0]           result_handle_o,
  output logic [pltn_pkg::CountW-1:0]            entry_count_o,
  output logic signed [pltn_pkg::CoordW-1:0]     out_x_o,
  output logic signed [pltn_pkg::CoordW-1:0]     out_y_o,
  output logic [pltn_pkg::RadiusW-1:0]           out_radius_o,
  output logic [pltn_pkg::ColorW-1:0]            out_red_o,
  output logic [pltn_pkg::ColorW-1:0]            out_green_o,
  output logic [pltn_pkg::ColorW-1:0]            out_blue_o
);
  import pltn_pkg::*;

  localparam int unsigned IdxW  = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_LIGHTS + 1);
  localparam int unsigned HExtW = (CntW > HandleW) ? CntW + 1 : HandleW + 1;
  localparam int unsigned OCntW = (CntW > CountW) ? CntW : CountW;
  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned SqW   = 2 * CoordW;
  localparam int unsigned DistW = SqW + 1;
  localparam logic [CntW-1:0] MaxCount = CntW'(MAX_LIGHTS);

  // captured input word
  op_e                    op_q;
  logic [HandleW-1:0]     handle_q;
  entry_t                 in_entry_q;

  logic [CntW-1:0]        count_q;

  // entry memory, one write and one registered read port
  entry_t                 mem_q [MAX_LIGHTS];
  entry_t                 rd_data_q;
  logic                   rd_en;
  logic [IdxW-1:0]        rd_addr;
  logic                   wr_en;
  logic [IdxW-1:0]        wr_addr;
  entry_t                 wr_data;

  logic [CntW-1:0]        ptr_q;
  logic [IdxW-1:0]        idx1_q, idx2_q, idx3_q;
  logic                   v1_q, v2_q, v3_q;

  logic signed [DiffW-1:0] dx_q, dy_q;
  logic [RadiusW-1:0]      r2_src_q;
  logic [SqW-1:0]          dx2_q, dy2_q, r2_q;
  logic signed [2*DiffW-1:0] dx_prod, dy_prod;
  logic [DistW-1:0]        sum_sq;

  logic [DistCapW-1:0]    best_q;
  logic [IdxW-1:0]        best_idx_q;
  logic                   found_q;

  status_e                res_status_q;
  logic [IdxW-1:0]        res_handle_q;

  logic [HExtW-1:0]       h_ext, cnt_ext, h_next;
  logic [IdxW-1:0]        h_idx;
  logic                   full, bad_handle, scan_done, step_ok;

  // output register
  logic                   out_valid_q;
  status_e                out_status_q;
  logic [HandleW-1:0]     out_handle_q;
  logic [CountW-1:0]      out_count_q;
  entry_t                 out_entry_q;
  status_e                fin_status;
  logic [IdxW-1:0]        fin_idx;
  logic [HExtW-1:0]       fin_idx_ext;
  logic [OCntW-1:0]       cnt_out_ext;

  assign h_ext      = HExtW'(handle_q);
  assign cnt_ext    = HExtW'(count_q);
  assign h_next     = h_ext + HExtW'(1);
  assign h_idx      = h_ext[IdxW-1:0];
  assign full       = (count_q == MaxCount);
  assign bad_handle = (h_ext >= cnt_ext);
  assign scan_done  = (ptr_q >= count_q);
  assign step_ok    = cmd_i.step && !scan_done;

  assign dp_status_o.op         = op_q;
  assign dp_status_o.full       = full;
  assign dp_status_o.bad_handle = bad_handle;
  assign dp_status_o.scan_done  = scan_done;
  assign dp_status_o.pipe_busy  = v1_q || v2_q || v3_q;
  assign dp_status_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q              <= op_e'(op_i);
      handle_q          <= handle_i;
      in_entry_q.x      <= pos_x_i;
      in_entry_q.y      <= pos_y_i;
      in_entry_q.radius <= radius_i;
      in_entry_q.red    <= red_i;
      in_entry_q.green  <= green_i;
      in_entry_q.blue   <= blue_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.append) begin
      count_q <= count_q + CntW'(1);
    end else if (cmd_i.shrink) begin
      count_q <= count_q - CntW'(1);
    end
  end

  // memory ports: a shift writes back the word read in the cycle before
  always_comb begin
    rd_en   = cmd_i.rd_handle || step_ok;
    rd_addr = cmd_i.rd_handle ? h_idx : ptr_q[IdxW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx1_q - IdxW'(1);
    wr_data = rd_data_q;
    if (cmd_i.append) begin
      wr_en   = 1'b1;
      wr_addr = count_q[IdxW-1:0];
      wr_data = in_entry_q;
    end else if (cmd_i.update) begin
      wr_en   = 1'b1;
      wr_addr = h_idx;
      wr_data = in_entry_q;
    end else if (v1_q && op_q == OP_REMOVE) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // scan pointer and pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      if (cmd_i.scan_init) begin
        ptr_q <= '0;
      end else if (cmd_i.shift_init) begin
        ptr_q <= h_next[CntW-1:0];
      end else if (step_ok) begin
        ptr_q <= ptr_q + CntW'(1);
      end
      v1_q <= step_ok;
      v2_q <= v1_q && (op_q == OP_FIND);
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_ok) begin
      idx1_q <= ptr_q[IdxW-1:0];
    end
  end

  // distance stages: difference, squares, then sum and compare
  assign dx_prod = (2*DiffW)'(dx_q) * (2*DiffW)'(dx_q);
  assign dy_prod = (2*DiffW)'(dy_q) * (2*DiffW)'(dy_q);
  assign sum_sq  = DistW'(dx2_q) + DistW'(dy2_q);

  always_ff @(posedge clk_i) begin
    dx_q     <= {rd_data_q.x[CoordW-1], rd_data_q.x} - {in_entry_q.x[CoordW-1], in_entry_q.x};
    dy_q     <= {rd_data_q.y[CoordW-1], rd_data_q.y} - {in_entry_q.y[CoordW-1], in_entry_q.y};
    r2_src_q <= rd_data_q.radius;
    idx2_q   <= idx1_q;
    dx2_q    <= dx_prod[SqW-1:0];
    dy2_q    <= dy_prod[SqW-1:0];
    r2_q     <= SqW'(r2_src_q) * SqW'(r2_src_q);
    idx3_q   <= idx2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan_init) begin
      found_q <= 1'b0;
    end else if (v3_q && sum_sq < DistW'(best_q) && sum_sq < DistW'(r2_q)) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      best_q <= DIST_CAP;
    end else if (v3_q && sum_sq < DistW'(best_q) && sum_sq < DistW'(r2_q)) begin
      best_q     <= sum_sq[DistCapW-1:0];
      best_idx_q <= idx3_q;
    end
  end

  // status and handle of the ops that settle at decode
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      res_status_q <= ST_OK;
      res_handle_q <= '0;
      case (op_q) inside
        OP_ADD: begin
          if (full) begin
            res_status_q <= ST_FULL;
          end else begin
            res_handle_q <= count_q[IdxW-1:0];
          end
        end
        OP_UPDATE, OP_REMOVE, OP_READ: begin
          if (bad_handle) begin
            res_status_q <= ST_BAD_HANDLE;
          end else begin
            res_handle_q <= h_idx;
          end
        end
        default: begin
          res_status_q <= ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    fin_status = res_status_q;
    fin_idx    = res_handle_q;
    if (op_q == OP_FIND) begin
      fin_status = found_q ? ST_OK : ST_NONE_FOUND;
      fin_idx    = found_q ? best_idx_q : '0;
    end
  end

  assign fin_idx_ext = HExtW'(fin_idx);
  assign cnt_out_ext = OCntW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q <= fin_status;
      out_handle_q <= fin_idx_ext[HandleW-1:0];
      out_count_q  <= cnt_out_ext[CountW-1:0];
      if (op_q == OP_READ && res_status_q == ST_OK) begin
        out_entry_q <= rd_data_q;
      end else begin
        out_entry_q <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign result_handle_o = out_handle_q;
  assign entry_count_o   = out_count_q;
  assign out_x_o         = out_entry_q.x;
  assign out_y_o         = out_entry_q.y;
  assign out_radius_o    = out_entry_q.radius;
  assign out_red_o       = out_entry_q.red;
  assign out_green_o     = out_entry_q.green;
  assign out_blue_o      = out_entry_q.blue;

endmodule

// ===== design/point_light_table_nearest_top.sv =====
// ----------------------------------------------------------------------------
// point_light_table_nearest_top
// Compacted table of point lights with append, update, remove, read and
// closest-within-radius search.
// ----------------------------------------------------------------------------
// The block takes one word at a time and returns one result word for each.
// All entries sit in a single-port-write, single-port-read memory, so the
// cost of an op follows from how many entries pass through that read port:
// add, update and unknown ops read no entry, read reads the one entry at
// the handle, remove reads every later entry and writes it back one place
// lower, one per cycle, and a closest search reads every live entry once
// and passes each through the distance pipeline of difference, squares,
// then sum and compare. A finished result sits in an output register; the
// next word is accepted once that result has been loaded there, and a
// result that is still waiting only delays the end of the following op.
// Entries beyond the count are never read.
module point_light_table_nearest_top #(
  parameter int unsigned MAX_LIGHTS = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [2:0]                             op_i,
  input  logic [pltn_pkg::HandleW-1:0]           handle_i,
  input  logic signed [pltn_pkg::CoordW-1:0]     pos_x_i,
  input  logic signed [pltn_pkg::CoordW-1:0]     pos_y_i,
  input  logic [pltn_pkg::RadiusW-1:0]           radius_i,
  input  logic [pltn_pkg::ColorW-1:0]            red_i,
  input  logic [pltn_pkg::ColorW-1:0]            green_i,
  input  logic [pltn_pkg::ColorW-1:0]            blue_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [1:0]                             status_o,
  output logic [pltn_pkg::HandleW-1:0]           result_handle_o,
  output logic [pltn_pkg::CountW-1:0]            entry_count_o,
  output logic signed [pltn_pkg::CoordW-1:0]     out_x_o,
  output logic signed [pltn_pkg::CoordW-1:0]     out_y_o,
  output logic [pltn_pkg::RadiusW-1:0]           out_radius_o,
  output logic [pltn_pkg::ColorW-1:0]            out_red_o,
  output logic [pltn_pkg::ColorW-1:0]            out_green_o,
  output logic [pltn_pkg::ColorW-1:0]            out_blue_o
);
  import pltn_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  pltn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  pltn_datapath #(
    .MAX_LIGHTS (MAX_LIGHTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .dp_status_o     (dp_status),
    .op_i            (op_i),
    .handle_i        (handle_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .radius_i        (radius_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .result_handle_o (result_handle_o),
    .entry_count_o   (entry_count_o),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .out_radius_o    (out_radius_o),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o)
  );

endmodule
